// File: src/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a second one in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("implication failed");

// Check that a condition implies a second one in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("next-cycle implication failed");

`endif

// File: src/q2a_pkg.sv
`timescale 1ns / 1ps
package q2a_pkg;
	// Datapath widths: vectors in Q2.30 plus growth, angle in 1/65536 centidegree
	localparam int XW = 38;
	localparam int ZW = 33;
	localparam int CFGW = 15;
	localparam int ANGW = 16;
	localparam int QW = 16;
	localparam int PW = 32;
	localparam int ATAN_LEN = 24;
	localparam int DEF_STAGES = 16;
	localparam logic [CFGW-1:0] SMALL_RESET = 15'd2621;
	localparam logic [CFGW-1:0] DOMINANT_RESET = 15'd19661;
	localparam logic signed [ZW-1:0] HALF_TURN = 33'sd1179648000;
	localparam logic signed [ZW-1:0] ROUND_HALF = 33'sd32768;
	localparam logic signed [ANGW:0] ANG_MAX = 17'sd18000;
	localparam logic signed [ANGW:0] ANG_MIN_EXCL = -17'sd18000;

	// Register indexes
	localparam logic REG_SMALL = 1'b0;
	localparam logic REG_DOMINANT = 1'b1;

	// One CORDIC lane: vector, angle and a force-to-zero mark
	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic zero;
	} lane_t;

	// atan(2^-i) in 1/65536 centidegree
	function automatic logic signed [ZW-1:0] atan_step(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 33'sd294912000;
			1: r = 33'sd174096719;
			2: r = 33'sd91987925;
			3: r = 33'sd46694507;
			4: r = 33'sd23437865;
			5: r = 33'sd11730358;
			6: r = 33'sd5866610;
			7: r = 33'sd2933484;
			8: r = 33'sd1466764;
			9: r = 33'sd733385;
			10: r = 33'sd366693;
			11: r = 33'sd183346;
			12: r = 33'sd91673;
			13: r = 33'sd45837;
			14: r = 33'sd22918;
			15: r = 33'sd11459;
			16: r = 33'sd5730;
			17: r = 33'sd2865;
			18: r = 33'sd1432;
			19: r = 33'sd716;
			20: r = 33'sd358;
			21: r = 33'sd179;
			22: r = 33'sd90;
			23: r = 33'sd45;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Fold a left-half vector into the right half and seed the angle
	function automatic lane_t lane_prep(input logic signed [XW-1:0] y,
			input logic signed [XW-1:0] x, input logic force_zero);
		lane_t l;
		l.zero = force_zero || (x == '0 && y == '0);
		if (x < 0) begin
			l.x = -x;
			l.y = -y;
			l.z = (y >= 0) ? HALF_TURN : -HALF_TURN;
		end else begin
			l.x = x;
			l.y = y;
			l.z = '0;
		end
		return l;
	endfunction

	function automatic logic signed [XW-1:0] mag(input logic signed [XW-1:0] v);
		return (v < 0) ? -v : v;
	endfunction
endpackage

// File: src/quaternion_to_full_range_angles_core.sv
`timescale 1ns / 1ps
// Channel | Dir | Fields (low bit first)
// s_*     | in  | tdata: quat_w, quat_x, quat_y, quat_z (16 bit signed each)
// m_*     | out | tdata: roll_centideg, pitch_centideg, yaw_centideg (16 bit signed each)
// cfg_*   | in  | index 0 small_component_limit, 1 dominant_component_limit
//
// One request per cycle while the output register is empty or taken. The
// pipeline is three front stages (products, axis terms, half-plane fold), one
// cell per CORDIC stage (at most ATAN_LEN) and the output register. arst_n
// clears the valid chain and reloads the default limits.
// The whole pipeline advances only when the output register is empty or taken.
module quaternion_to_full_range_angles_core #(
	parameter int CORDIC_STAGES = q2a_pkg::DEF_STAGES
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [63:0] s_tdata, // quat_w, quat_x, quat_y, quat_z
	output logic m_tvalid,
	input logic m_tready,
	output logic [47:0] m_tdata, // roll_centideg, pitch_centideg, yaw_centideg
	input logic cfg_we,
	input logic cfg_index,
	input logic [q2a_pkg::CFGW-1:0] cfg_data
);
	import q2a_pkg::*;
	`include "assert_macros.svh"

	localparam int NCELL = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
	localparam int PL = 3 + NCELL;

	logic en;
	logic [PL-1:0] vld_q;
	logic out_vld_q;
	logic [CFGW-1:0] small_q, dominant_q;
	lane_t chain [3][NCELL+1];
	logic signed [ANGW-1:0] ang [3];
	logic signed [ANGW-1:0] ang_q [3];

	assign en = !out_vld_q || m_tready;
	assign s_tready = en;

	// Limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_q <= SMALL_RESET;
			dominant_q <= DOMINANT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SMALL: small_q <= cfg_data;
				REG_DOMINANT: dominant_q <= cfg_data;
				default: ;
			endcase
		end
	end

	q2a_front u_front (
		.clk(clk),
		.en(en),
		.quat_w(s_tdata[15:0]),
		.quat_x(s_tdata[31:16]),
		.quat_y(s_tdata[47:32]),
		.quat_z(s_tdata[63:48]),
		.small_limit(small_q),
		.dominant_limit(dominant_q),
		.roll_lane(chain[0][0]),
		.pitch_lane(chain[1][0]),
		.yaw_lane(chain[2][0])
	);

	// Row of CORDIC cells for each angle
	for (genvar a = 0; a < 3; a++) begin : g_lane
		for (genvar i = 0; i < NCELL; i++) begin : g_cell
			q2a_cell #(.STAGE(i)) u_cell (
				.clk(clk),
				.en(en),
				.lane_in(chain[a][i]),
				.lane_out(chain[a][i+1])
			);
		end
	end

	// Round to centidegrees, zero marked lanes and fold the range ends onto +180
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic signed [ZW-1:0] zr;
			logic signed [ANGW:0] cd;
			zr = chain[a][NCELL].z + ROUND_HALF;
			cd = (ANGW+1)'(zr >>> 16);
			if (chain[a][NCELL].zero) begin
				ang[a] = '0;
			end else if (cd > ANG_MAX || cd <= ANG_MIN_EXCL) begin
				ang[a] = ANGW'(ANG_MAX);
			end else begin
				ang[a] = ANGW'(cd);
			end
		end
	end

	// Valid chain and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[PL-2:0], s_tvalid};
			out_vld_q <= vld_q[PL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_q <= ang;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {ang_q[2], ang_q[1], ang_q[0]};

	`ASSERT_IMPLIES(a_range, clk, arst_n, m_tvalid,
		($signed(m_tdata[15:0]) <= 18000) && ($signed(m_tdata[15:0]) >= -17999))
	`ASSERT_IMPLIES(a_hold, clk, arst_n, m_tvalid && !m_tready, !s_tready)
	`ASSERT_NEXT(a_enter, clk, arst_n, s_tvalid && s_tready, vld_q[0])
endmodule

// File: src/q2a_cell.sv
`timescale 1ns / 1ps
module q2a_cell #(
	parameter int STAGE = 0
) (
	input logic clk,
	input logic en,
	input q2a_pkg::lane_t lane_in,
	output q2a_pkg::lane_t lane_out
);
	import q2a_pkg::*;

	localparam logic signed [ZW-1:0] STEP = atan_step(STAGE);

	lane_t nxt;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;

	// Rotate toward the x axis by one micro-angle
	always_comb begin
		xs = lane_in.x >>> STAGE;
		ys = lane_in.y >>> STAGE;
		nxt.zero = lane_in.zero;
		if (lane_in.y > 0) begin
			nxt.x = lane_in.x + ys;
			nxt.y = lane_in.y - xs;
			nxt.z = lane_in.z + STEP;
		end else begin
			nxt.x = lane_in.x - ys;
			nxt.y = lane_in.y + xs;
			nxt.z = lane_in.z - STEP;
		end
	end

	// Hand the lane to the next cell
	always_ff @(posedge clk) begin
		if (en) begin
			lane_out <= nxt;
		end
	end
endmodule

// File: src/q2a_front.sv
`timescale 1ns / 1ps
module q2a_front (
	input logic clk,
	input logic en,
	input logic signed [q2a_pkg::QW-1:0] quat_w,
	input logic signed [q2a_pkg::QW-1:0] quat_x,
	input logic signed [q2a_pkg::QW-1:0] quat_y,
	input logic signed [q2a_pkg::QW-1:0] quat_z,
	input logic [q2a_pkg::CFGW-1:0] small_limit,
	input logic [q2a_pkg::CFGW-1:0] dominant_limit,
	output q2a_pkg::lane_t roll_lane,
	output q2a_pkg::lane_t pitch_lane,
	output q2a_pkg::lane_t yaw_lane
);
	import q2a_pkg::*;

	localparam logic signed [XW-1:0] ONE_Q30 = XW'(64'sd1 << 30);
	localparam logic signed [XW-1:0] HALF_Q30 = XW'(64'sd1 << 29);

	logic signed [PW-1:0] p_xz_s1, p_wy_s1, p_yz_s1, p_wx_s1;
	logic signed [PW-1:0] p_xx_s1, p_yy_s1, p_wz_s1, p_xy_s1, p_zz_s1;
	logic signed [XW-1:0] dx_s2, dy_s2, dz_s2, yn_s2, yd_s2;
	logic sup_roll_s2, sup_pitch_s2;
	logic signed [XW-1:0] dx, dy, dz, yn, yd;
	logic [XW-1:0] small_q30, dom_q30;

	// Stage 1: products in Q2.30
	always_ff @(posedge clk) begin
		if (en) begin
			p_xz_s1 <= quat_x * quat_z;
			p_wy_s1 <= quat_w * quat_y;
			p_yz_s1 <= quat_y * quat_z;
			p_wx_s1 <= quat_w * quat_x;
			p_xx_s1 <= quat_x * quat_x;
			p_yy_s1 <= quat_y * quat_y;
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_zz_s1 <= quat_z * quat_z;
		end
	end

	// Stage 2: down axis, yaw terms and cross-axis suppression
	always_comb begin
		dx = (XW'(p_xz_s1) - XW'(p_wy_s1)) <<< 1;
		dy = (XW'(p_yz_s1) + XW'(p_wx_s1)) <<< 1;
		dz = ONE_Q30 - ((XW'(p_xx_s1) + XW'(p_yy_s1)) <<< 1);
		yn = XW'(p_wz_s1) + XW'(p_xy_s1);
		yd = HALF_Q30 - XW'(p_yy_s1) - XW'(p_zz_s1);
		small_q30 = XW'(small_limit) << 15;
		dom_q30 = XW'(dominant_limit) << 15;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2 <= dx;
			dy_s2 <= dy;
			dz_s2 <= dz;
			yn_s2 <= yn;
			yd_s2 <= yd;
			sup_roll_s2 <= (unsigned'(mag(dy)) < small_q30) && (unsigned'(mag(dx)) > dom_q30);
			sup_pitch_s2 <= (unsigned'(mag(dx)) < small_q30) && (unsigned'(mag(dy)) > dom_q30);
		end
	end

	// Stage 3: fold into the right half plane
	always_ff @(posedge clk) begin
		if (en) begin
			roll_lane <= lane_prep(dy_s2, dz_s2, sup_roll_s2);
			pitch_lane <= lane_prep(-dx_s2, dz_s2, sup_pitch_s2);
			yaw_lane <= lane_prep(yn_s2, yd_s2, 1'b0);
		end
	end
endmodule
